// ===== rtl/gprf_pkg.sv =====
// Shared types and constants for the GPS response framer.
// Used by gprf_front, gprf_back and gps_response_framer_unit; no dependencies.
package gprf_pkg;

  localparam int BUFFER_DEPTH = 512;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int MAXLEN_W     = 10;
  localparam int LIM_W        = (IDX_W > MAXLEN_W) ? IDX_W : MAXLEN_W;
  localparam int TICK_W       = 16;
  localparam int POS_W        = 9;
  localparam int LEN_W        = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd1;

  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [TICK_W-1:0]   TIMEOUT_RESET = 16'd2000;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET  = 10'd400;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HUNT = 4'b0010,
    PH_HEAD = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       is_start;
    logic       is_byte;
    logic       is_tick;
    logic       is_lt;
    logic       is_lf;
    logic       is_cr;
    logic [7:0] rx_byte;
  } q_item_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data_byte;
    logic [POS_W-1:0] position;
    logic [1:0]       status;
    logic [LEN_W-1:0] length;
    logic             last;
  } result_t;

endpackage

// ===== rtl/gprf_front.sv =====
// Front end: classifies accepted beats; queues known commands for the back end.
// Depends on gprf_pkg.
module gprf_front
  import gprf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [7:0] rx_byte,
  output logic       q_valid,
  input  logic       q_ready,
  output q_item_t    q_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  q_item_t              cls;
  logic                 keep;
  logic                 push;
  logic                 pop;

  always_comb begin
    cls         = '0;
    keep        = 1'b1;
    cls.rx_byte = rx_byte;
    cls.is_lt   = (rx_byte == CH_LT);
    cls.is_lf   = (rx_byte == CH_LF);
    cls.is_cr   = (rx_byte == CH_CR);
    unique case (command)
      CMD_START: cls.is_start = 1'b1;
      CMD_BYTE:  cls.is_byte  = 1'b1;
      CMD_TICK:  cls.is_tick  = 1'b1;
      default:   keep         = 1'b0;
    endcase
  end

  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - CNT_W'(1)))
    else $error("queue count did not shrink on pop");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count above depth");

endmodule

// ===== rtl/gprf_back.sv =====
// Back end: runs the framing state machine on queued beats and holds the result register.
// Depends on gprf_pkg.
module gprf_back
  import gprf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  q_item_t             q_item,
  input  logic [TICK_W-1:0]   timeout_ticks,
  input  logic [MAXLEN_W-1:0] max_length,
  output logic                res_valid,
  input  logic                res_ready,
  output result_t             res
);

  phase_t            phase;
  phase_t            phase_next;
  phase_t            eff_phase;
  logic              prev_cr;
  logic              prev_cr_next;
  logic [IDX_W-1:0]  byte_index;
  logic [IDX_W-1:0]  byte_index_next;
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] tick_count_next;
  logic [TICK_W-1:0] tick_sat;
  logic [LIM_W-1:0]  limit;
  logic              crlf;
  logic              emit;
  logic              pop;
  result_t           res_d;

  assign q_ready  = !res_valid || res_ready;
  assign pop      = q_valid && q_ready;
  assign tick_sat = (tick_count == '1) ? tick_count : tick_count + TICK_W'(1);
  assign limit    = (LIM_W'(max_length) < LIM_W'(BUFFER_DEPTH)) ? LIM_W'(max_length)
                                                                 : LIM_W'(BUFFER_DEPTH);
  assign crlf     = q_item.is_lf && prev_cr;

  always_comb begin
    phase_next      = phase;
    prev_cr_next    = prev_cr;
    byte_index_next = byte_index;
    tick_count_next = tick_count;
    eff_phase       = phase;
    emit            = 1'b0;
    res_d           = '0;
    if (q_item.is_start) begin
      phase_next      = PH_HUNT;
      prev_cr_next    = 1'b0;
      byte_index_next = '0;
      tick_count_next = '0;
    end else if (phase != PH_IDLE) begin
      if (q_item.is_tick) begin
        tick_count_next = tick_sat;
        if (tick_sat >= timeout_ticks) begin
          emit         = 1'b1;
          res_d.kind   = 1'b1;
          res_d.status = ST_TIMEOUT;
          res_d.last   = 1'b1;
          phase_next   = PH_IDLE;
        end
      end else if (q_item.is_byte) begin
        if (phase == PH_HUNT && !q_item.is_lt) begin
          prev_cr_next = q_item.is_cr;
        end else begin
          if (phase == PH_HUNT) begin
            eff_phase       = PH_HEAD;
            tick_count_next = '0;
          end
          if (crlf && eff_phase == PH_BODY) begin
            emit         = 1'b1;
            res_d.kind   = 1'b1;
            res_d.status = ST_OK;
            res_d.length = (byte_index != '0) ? LEN_W'(byte_index - IDX_W'(1)) : '0;
            res_d.last   = 1'b1;
            phase_next   = PH_IDLE;
          end else begin
            if (crlf) begin
              eff_phase = PH_BODY;
            end
            if (LIM_W'(byte_index) >= limit) begin
              emit         = 1'b1;
              res_d.kind   = 1'b1;
              res_d.status = ST_OVERFLOW;
              res_d.last   = 1'b1;
              phase_next   = PH_IDLE;
            end else begin
              emit            = 1'b1;
              res_d.data_byte = q_item.rx_byte;
              res_d.position  = POS_W'(byte_index);
              byte_index_next = byte_index + IDX_W'(1);
              prev_cr_next    = q_item.is_cr;
              phase_next      = eff_phase;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      prev_cr    <= 1'b0;
      byte_index <= '0;
      tick_count <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (pop) begin
        phase      <= phase_next;
        prev_cr    <= prev_cr_next;
        byte_index <= byte_index_next;
        tick_count <= tick_count_next;
        res_valid  <= emit;
      end else if (res_ready) begin
        res_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_d;
    end
  end

  a_status_idles: assert property (@(posedge clk) disable iff (rst)
    (pop && emit && res_d.kind) |=> (phase == PH_IDLE))
    else $error("status beat did not return framer to idle");

  a_byte_advances: assert property (@(posedge clk) disable iff (rst)
    (pop && emit && !res_d.kind) |=> (byte_index == $past(byte_index) + IDX_W'(1)))
    else $error("stored byte did not advance index");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("stalled result beat changed");

endmodule

// ===== rtl/gps_response_framer_unit.sv =====
// GPS response framer top level over gprf_front and gprf_back; depends on gprf_pkg.
// Output is registered: a beat passes the queue, then the result register.
// Throughput: one beat per cycle; in_ready drops only when the two-entry queue is full
// because the result register is stalled by out_ready.
// Reset (rst, synchronous): framer idle, queue and result register empty,
// timeout_ticks to 2000, max_length to 400. No clearing pass; ready right after reset.
module gps_response_framer_unit
  import gprf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  logic [7:0]            rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  kind,
  output logic [7:0]            data_byte,
  output logic [POS_W-1:0]      position,
  output logic [1:0]            status,
  output logic [LEN_W-1:0]      length,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [TICK_W-1:0]   timeout_ticks;
  logic [MAXLEN_W-1:0] max_length;
  logic                q_valid;
  logic                q_ready;
  q_item_t             q_item;
  result_t             res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      max_length    <= MAXLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TICK_W-1:0];
        CFG_MAX_LENGTH:    max_length    <= cfg_data[MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  gprf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  gprf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .timeout_ticks (timeout_ticks),
    .max_length    (max_length),
    .res_valid     (out_valid),
    .res_ready     (out_ready),
    .res           (res)
  );

  assign kind      = res.kind;
  assign data_byte = res.data_byte;
  assign position  = res.position;
  assign status    = res.status;
  assign length    = res.length;
  assign last      = res.last;

endmodule
